// ----- src/clst_pkg.sv -----
// ----------------------------------------------------------------------------
// clst_pkg: shared definitions for the source tokenizer
// Field widths, queue sizing, token kind codes and the token record that
// travels from the lexer into the result queue.
// ----------------------------------------------------------------------------
package clst_pkg;

   // Field widths
   localparam int POS_W    = 16;
   localparam int OFF_W    = 32;
   localparam int LEN_W    = 16;
   localparam int VAL_W    = 63;
   localparam int KIND_W   = 6;
   localparam int KW_CHARS = 6;
   localparam int KW_BITS  = 8 * KW_CHARS;

   // Result queue sizing
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // Token kind codes
   localparam logic [KIND_W-1:0] TK_IDENT   = 6'd0;
   localparam logic [KIND_W-1:0] TK_NUMBER  = 6'd1;
   localparam logic [KIND_W-1:0] TK_STRING  = 6'd2;
   localparam logic [KIND_W-1:0] TK_INT     = 6'd3;
   localparam logic [KIND_W-1:0] TK_VOID    = 6'd4;
   localparam logic [KIND_W-1:0] TK_IF      = 6'd5;
   localparam logic [KIND_W-1:0] TK_ELSE    = 6'd6;
   localparam logic [KIND_W-1:0] TK_WHILE   = 6'd7;
   localparam logic [KIND_W-1:0] TK_RETURN  = 6'd8;
   localparam logic [KIND_W-1:0] TK_ASM     = 6'd9;
   localparam logic [KIND_W-1:0] TK_CONST   = 6'd10;
   localparam logic [KIND_W-1:0] TK_LPAREN  = 6'd11;
   localparam logic [KIND_W-1:0] TK_RPAREN  = 6'd12;
   localparam logic [KIND_W-1:0] TK_LBRACE  = 6'd13;
   localparam logic [KIND_W-1:0] TK_RBRACE  = 6'd14;
   localparam logic [KIND_W-1:0] TK_LBRACK  = 6'd15;
   localparam logic [KIND_W-1:0] TK_RBRACK  = 6'd16;
   localparam logic [KIND_W-1:0] TK_SEMI    = 6'd17;
   localparam logic [KIND_W-1:0] TK_COMMA   = 6'd18;
   localparam logic [KIND_W-1:0] TK_PLUS    = 6'd19;
   localparam logic [KIND_W-1:0] TK_MINUS   = 6'd20;
   localparam logic [KIND_W-1:0] TK_STAR    = 6'd21;
   localparam logic [KIND_W-1:0] TK_SLASH   = 6'd22;
   localparam logic [KIND_W-1:0] TK_PERCENT = 6'd23;
   localparam logic [KIND_W-1:0] TK_CARET   = 6'd24;
   localparam logic [KIND_W-1:0] TK_AMP     = 6'd25;
   localparam logic [KIND_W-1:0] TK_PIPE    = 6'd26;
   localparam logic [KIND_W-1:0] TK_ASSIGN  = 6'd27;
   localparam logic [KIND_W-1:0] TK_EQ      = 6'd28;
   localparam logic [KIND_W-1:0] TK_NOT     = 6'd29;
   localparam logic [KIND_W-1:0] TK_NE      = 6'd30;
   localparam logic [KIND_W-1:0] TK_LT      = 6'd31;
   localparam logic [KIND_W-1:0] TK_LE      = 6'd32;
   localparam logic [KIND_W-1:0] TK_SHL     = 6'd33;
   localparam logic [KIND_W-1:0] TK_GT      = 6'd34;
   localparam logic [KIND_W-1:0] TK_GE      = 6'd35;
   localparam logic [KIND_W-1:0] TK_SHR     = 6'd36;
   localparam logic [KIND_W-1:0] TK_END     = 6'd37;

   // One result token
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [POS_W-1:0]  line;
      logic [POS_W-1:0]  column;
      logic [OFF_W-1:0]  offset;
      logic [LEN_W-1:0]  length;
      logic [VAL_W-1:0]  value;
      logic              overflow;
      logic              last;
   } token_type;

   // Tokens produced by one source beat: none, one or two
   typedef struct packed {
      logic [1:0] count;
      token_type  first;
      token_type  second;
   } push_type;

endpackage

// ----- src/c_like_source_tokenizer.sv -----
// Path: a source beat goes through the input register into the result queue before
// its result beat is offered. Throughput: one source beat per cycle while the queue
// has room for two tokens; a two-token beat is absorbed by the four-entry result queue.
// Reset: synchronous, active high; returns the scanner to line 1, column 1,
// offset 0 and empties the input register and result queue.
// ----------------------------------------------------------------------------
// c_like_source_tokenizer: streaming lexer for a small C-like language
// Source bytes enter through an input register, the lexer decides the tokens
// of each byte in one pass, and tokens leave through a result queue.
// ----------------------------------------------------------------------------
module c_like_source_tokenizer (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] ch
   input  logic         req_tuser,   // [0] kind (end of source)
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [143:0] rsp_tdata,   // [15:0] start_line, [31:16] start_column,
                                     // [63:32] start_offset, [79:64] text_length,
                                     // [142:80] number_value, [143] overflow
   output logic [5:0]   rsp_tuser,   // [5:0] token_kind
   output logic         rsp_tlast    // last_result
);

   // Input register
   logic       in_valid_ff, in_valid_in;
   logic       in_end_ff;
   logic [7:0] in_ch_ff;
   logic       fire, room, accept;

   assign fire        = in_valid_ff && room;
   assign req_tready  = !in_valid_ff || fire;
   assign accept      = req_tvalid && req_tready;
   assign in_valid_in = accept ? 1'b1 : (fire ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_end_ff <= req_tuser;
         in_ch_ff  <= req_tdata;
      end
   end

   // Lexer
   clst_pkg::push_type push;

   clst_lexer u_lexer (
      .clock   (clock),
      .reset   (reset),
      .step    (fire),
      .src_end (in_end_ff),
      .src_ch  (in_ch_ff),
      .push    (push)
   );

   // Result queue
   clst_pkg::token_type head;
   logic                pop;

   assign pop = rsp_tvalid && rsp_tready;

   clst_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .head      (head),
      .not_empty (rsp_tvalid),
      .room      (room)
   );

   // Result beat packing
   assign rsp_tdata = {head.overflow, head.value, head.length, head.offset,
                       head.column, head.line};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

endmodule

// ----- src/clst_lexer.sv -----
// ----------------------------------------------------------------------------
// clst_lexer: scanner state and per-beat token decisions
// Holds the scan mode, position counters and the token being built, and
// works out in one pass which tokens (at most two) a source beat produces.
// ----------------------------------------------------------------------------
module clst_lexer (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic              src_end,
   input  logic [7:0]        src_ch,
   output clst_pkg::push_type push
);

   typedef enum logic [3:0] {
      M_IDLE,
      M_IDENT,
      M_NUMBER,
      M_STRING,
      M_SLASH,
      M_OPER,
      M_LINE,
      M_BLOCK,
      M_BLOCK_STAR
   } mode_type;

   localparam int AW = clst_pkg::VAL_W + 4;

   // Single-character operator code, or identifier code when not an operator
   function automatic logic [clst_pkg::KIND_W-1:0] single_op(input logic [7:0] c);
      logic [clst_pkg::KIND_W-1:0] k;
      begin
         case (c)
            "(": k = clst_pkg::TK_LPAREN;
            ")": k = clst_pkg::TK_RPAREN;
            "{": k = clst_pkg::TK_LBRACE;
            "}": k = clst_pkg::TK_RBRACE;
            "[": k = clst_pkg::TK_LBRACK;
            "]": k = clst_pkg::TK_RBRACK;
            ";": k = clst_pkg::TK_SEMI;
            ",": k = clst_pkg::TK_COMMA;
            "+": k = clst_pkg::TK_PLUS;
            "-": k = clst_pkg::TK_MINUS;
            "*": k = clst_pkg::TK_STAR;
            "%": k = clst_pkg::TK_PERCENT;
            "^": k = clst_pkg::TK_CARET;
            "&": k = clst_pkg::TK_AMP;
            "|": k = clst_pkg::TK_PIPE;
            "=": k = clst_pkg::TK_ASSIGN;
            "!": k = clst_pkg::TK_NOT;
            "<": k = clst_pkg::TK_LT;
            ">": k = clst_pkg::TK_GT;
            default: k = clst_pkg::TK_IDENT;
         endcase
         return k;
      end
   endfunction

   // Two-character operator code, or identifier code when the pair is no operator
   function automatic logic [clst_pkg::KIND_W-1:0] pair_op(input logic [7:0] p,
                                                           input logic [7:0] c);
      logic [clst_pkg::KIND_W-1:0] k;
      begin
         k = clst_pkg::TK_IDENT;
         if (c == "=" && p == "=") k = clst_pkg::TK_EQ;
         else if (c == "=" && p == "!") k = clst_pkg::TK_NE;
         else if (c == "=" && p == "<") k = clst_pkg::TK_LE;
         else if (c == "<" && p == "<") k = clst_pkg::TK_SHL;
         else if (c == "=" && p == ">") k = clst_pkg::TK_GE;
         else if (c == ">" && p == ">") k = clst_pkg::TK_SHR;
         return k;
      end
   endfunction

   // Keyword lookup on the identifier length and its first bytes
   function automatic logic [clst_pkg::KIND_W-1:0] keyword_kind(
      input logic [clst_pkg::LEN_W-1:0]   len,
      input logic [clst_pkg::KW_BITS-1:0] pfx);
      logic [clst_pkg::KIND_W-1:0] k;
      begin
         k = clst_pkg::TK_IDENT;
         if (len == clst_pkg::LEN_W'(3) && pfx == clst_pkg::KW_BITS'(64'h746E69))
            k = clst_pkg::TK_INT;
         else if (len == clst_pkg::LEN_W'(4) && pfx == clst_pkg::KW_BITS'(64'h64696F76))
            k = clst_pkg::TK_VOID;
         else if (len == clst_pkg::LEN_W'(2) && pfx == clst_pkg::KW_BITS'(64'h6669))
            k = clst_pkg::TK_IF;
         else if (len == clst_pkg::LEN_W'(4) && pfx == clst_pkg::KW_BITS'(64'h65736C65))
            k = clst_pkg::TK_ELSE;
         else if (len == clst_pkg::LEN_W'(5) && pfx == clst_pkg::KW_BITS'(64'h656C696877))
            k = clst_pkg::TK_WHILE;
         else if (len == clst_pkg::LEN_W'(6) && pfx == clst_pkg::KW_BITS'(64'h6E7275746572))
            k = clst_pkg::TK_RETURN;
         else if (len == clst_pkg::LEN_W'(3) && pfx == clst_pkg::KW_BITS'(64'h6D7361))
            k = clst_pkg::TK_ASM;
         else if (len == clst_pkg::LEN_W'(5) && pfx == clst_pkg::KW_BITS'(64'h74736E6F63))
            k = clst_pkg::TK_CONST;
         return k;
      end
   endfunction

   // Scanner state
   mode_type                     mode_ff, mode_in;
   logic [7:0]                   pend_ff, pend_in;
   logic [clst_pkg::POS_W-1:0]   cur_line_ff, cur_line_in;
   logic [clst_pkg::POS_W-1:0]   cur_col_ff, cur_col_in;
   logic [clst_pkg::OFF_W-1:0]   cur_off_ff, cur_off_in;
   logic [clst_pkg::POS_W-1:0]   tok_line_ff, tok_line_in;
   logic [clst_pkg::POS_W-1:0]   tok_col_ff, tok_col_in;
   logic [clst_pkg::OFF_W-1:0]   tok_off_ff, tok_off_in;
   logic [clst_pkg::VAL_W-1:0]   acc_ff, acc_in;
   logic                         ovf_ff, ovf_in;
   logic [clst_pkg::LEN_W-1:0]   len_ff, len_in;
   logic [clst_pkg::KW_BITS-1:0] pfx_ff, pfx_in;

   // Character classes
   logic c_space, c_alpha, c_digit, c_oper, c_nl;

   assign c_space = (src_ch == " ") || (src_ch >= 8'd9 && src_ch <= 8'd13);
   assign c_alpha = (src_ch >= "a" && src_ch <= "z") || (src_ch >= "A" && src_ch <= "Z") ||
                    (src_ch == "_");
   assign c_digit = (src_ch >= "0" && src_ch <= "9");
   assign c_oper  = (src_ch == "=") || (src_ch == "!") || (src_ch == "<") || (src_ch == ">");
   assign c_nl    = (src_ch == 8'h0A);

   // Saturating length and identifier prefix growth
   logic [clst_pkg::LEN_W-1:0]   len_inc;
   logic [clst_pkg::KW_BITS-1:0] pfx_add;

   assign len_inc = (len_ff == '1) ? len_ff : len_ff + clst_pkg::LEN_W'(1);

   always_comb begin
      pfx_add = pfx_ff;
      for (int i = 0; i < clst_pkg::KW_CHARS; i++) begin
         if (len_ff == clst_pkg::LEN_W'(i)) pfx_add[8*i +: 8] = src_ch;
      end
   end

   // Decimal accumulate: times ten by shift and add, saturate past the top
   logic [AW-1:0]              acc_sum;
   logic                       acc_over;
   logic [clst_pkg::VAL_W-1:0] acc_add;

   assign acc_sum  = AW'({acc_ff, 3'b000}) + AW'({acc_ff, 1'b0}) + AW'(src_ch[3:0]);
   assign acc_over = |acc_sum[AW-1:clst_pkg::VAL_W];
   assign acc_add  = acc_over ? '1 : acc_sum[clst_pkg::VAL_W-1:0];

   // Position after this byte
   logic [clst_pkg::POS_W-1:0] line_adv, col_adv;
   logic [clst_pkg::OFF_W-1:0] off_adv;

   assign line_adv = (c_nl && cur_line_ff != '1) ? cur_line_ff + clst_pkg::POS_W'(1)
                                                 : cur_line_ff;
   assign col_adv  = c_nl ? clst_pkg::POS_W'(1) :
                     (cur_col_ff != '1) ? cur_col_ff + clst_pkg::POS_W'(1) : cur_col_ff;
   assign off_adv  = cur_off_ff + clst_pkg::OFF_W'(1);

   // Token that a pending scan mode yields when it is closed
   clst_pkg::token_type flush_tok;
   logic                flush_has;

   always_comb begin
      flush_tok          = '0;
      flush_tok.line     = tok_line_ff;
      flush_tok.column   = tok_col_ff;
      flush_tok.offset   = tok_off_ff;
      flush_has          = 1'b1;
      case (mode_ff)
         M_IDENT: begin
            flush_tok.kind   = keyword_kind(len_ff, pfx_ff);
            flush_tok.length = len_ff;
         end
         M_NUMBER: begin
            flush_tok.kind     = clst_pkg::TK_NUMBER;
            flush_tok.length   = len_ff;
            flush_tok.value    = acc_ff;
            flush_tok.overflow = ovf_ff;
         end
         M_STRING: begin
            flush_tok.kind   = clst_pkg::TK_STRING;
            flush_tok.length = len_ff;
         end
         M_SLASH: begin
            flush_tok.kind   = clst_pkg::TK_SLASH;
            flush_tok.length = clst_pkg::LEN_W'(1);
         end
         M_OPER: begin
            flush_tok.kind   = single_op(pend_ff);
            flush_tok.length = clst_pkg::LEN_W'(1);
         end
         default: flush_has = 1'b0;
      endcase
   end

   // What a byte starts when nothing is pending
   mode_type                     st_mode;
   logic [clst_pkg::LEN_W-1:0]   st_len;
   logic [clst_pkg::KW_BITS-1:0] st_pfx;
   logic [clst_pkg::VAL_W-1:0]   st_acc;
   logic                         st_emit;
   logic [clst_pkg::KIND_W-1:0]  st_op;
   clst_pkg::token_type          st_tok;

   assign st_op = single_op(src_ch);

   always_comb begin
      st_mode = M_IDLE;
      st_len  = '0;
      st_pfx  = '0;
      st_acc  = '0;
      st_emit = 1'b0;
      if (c_space) begin
         st_mode = M_IDLE;
      end else if (c_alpha) begin
         st_mode = M_IDENT;
         st_len  = clst_pkg::LEN_W'(1);
         st_pfx  = clst_pkg::KW_BITS'(src_ch);
      end else if (c_digit) begin
         st_mode = M_NUMBER;
         st_len  = clst_pkg::LEN_W'(1);
         st_acc  = clst_pkg::VAL_W'(src_ch[3:0]);
      end else if (src_ch == "\"") begin
         st_mode = M_STRING;
      end else if (src_ch == "/") begin
         st_mode = M_SLASH;
      end else if (c_oper) begin
         st_mode = M_OPER;
      end else begin
         st_emit = (st_op != clst_pkg::TK_IDENT);
      end
   end

   always_comb begin
      st_tok        = '0;
      st_tok.kind   = st_op;
      st_tok.line   = cur_line_ff;
      st_tok.column = cur_col_ff;
      st_tok.offset = cur_off_ff;
      st_tok.length = clst_pkg::LEN_W'(1);
   end

   // Per-beat decision and next state
   logic                        do_flush, do_start, do_pair, b_valid;
   logic [clst_pkg::KIND_W-1:0] pair_kind;
   clst_pkg::token_type         tok_b;

   assign pair_kind = pair_op(pend_ff, src_ch);

   always_comb begin
      mode_in     = mode_ff;
      pend_in     = pend_ff;
      cur_line_in = cur_line_ff;
      cur_col_in  = cur_col_ff;
      cur_off_in  = cur_off_ff;
      tok_line_in = tok_line_ff;
      tok_col_in  = tok_col_ff;
      tok_off_in  = tok_off_ff;
      acc_in      = acc_ff;
      ovf_in      = ovf_ff;
      len_in      = len_ff;
      pfx_in      = pfx_ff;
      do_flush    = 1'b0;
      do_start    = 1'b0;
      do_pair     = 1'b0;
      b_valid     = 1'b0;
      tok_b       = st_tok;

      if (step && src_end) begin
         // End of source: close the pending token, report the end, restart
         do_flush      = 1'b1;
         b_valid       = 1'b1;
         tok_b         = '0;
         tok_b.kind    = clst_pkg::TK_END;
         tok_b.line    = cur_line_ff;
         tok_b.column  = cur_col_ff;
         tok_b.offset  = cur_off_ff;
         mode_in       = M_IDLE;
         pend_in       = '0;
         cur_line_in   = clst_pkg::POS_W'(1);
         cur_col_in    = clst_pkg::POS_W'(1);
         cur_off_in    = '0;
         tok_line_in   = clst_pkg::POS_W'(1);
         tok_col_in    = clst_pkg::POS_W'(1);
         tok_off_in    = '0;
         acc_in        = '0;
         ovf_in        = 1'b0;
         len_in        = '0;
         pfx_in        = '0;
      end else if (step) begin
         case (mode_ff)
            M_IDENT: begin
               if (c_alpha || c_digit) begin
                  len_in = len_inc;
                  pfx_in = pfx_add;
               end else begin
                  do_flush = 1'b1;
                  do_start = 1'b1;
               end
            end
            M_NUMBER: begin
               if (c_digit) begin
                  len_in = len_inc;
                  acc_in = acc_add;
                  ovf_in = ovf_ff | acc_over;
               end else begin
                  do_flush = 1'b1;
                  do_start = 1'b1;
               end
            end
            M_STRING: begin
               if (src_ch == "\"") begin
                  do_flush = 1'b1;
                  mode_in  = M_IDLE;
               end else begin
                  len_in = len_inc;
               end
            end
            M_SLASH: begin
               if (src_ch == "/") mode_in = M_LINE;
               else if (src_ch == "*") mode_in = M_BLOCK;
               else begin
                  do_flush = 1'b1;
                  do_start = 1'b1;
               end
            end
            M_OPER: begin
               if (pair_kind != clst_pkg::TK_IDENT) begin
                  do_pair = 1'b1;
                  mode_in = M_IDLE;
               end else begin
                  do_flush = 1'b1;
                  do_start = 1'b1;
               end
            end
            M_LINE: begin
               if (c_nl) mode_in = M_IDLE;
            end
            M_BLOCK: begin
               if (src_ch == "*") mode_in = M_BLOCK_STAR;
            end
            M_BLOCK_STAR: begin
               if (src_ch == "/") mode_in = M_IDLE;
               else if (src_ch != "*") mode_in = M_BLOCK;
            end
            default: do_start = 1'b1;
         endcase

         // A byte that opens something new resets the token under construction
         if (do_start) begin
            mode_in     = st_mode;
            tok_line_in = cur_line_ff;
            tok_col_in  = cur_col_ff;
            tok_off_in  = cur_off_ff;
            len_in      = st_len;
            pfx_in      = st_pfx;
            acc_in      = st_acc;
            ovf_in      = 1'b0;
            b_valid     = st_emit;
            if (c_oper) pend_in = src_ch;
         end

         if (do_pair) begin
            b_valid       = 1'b1;
            tok_b         = '0;
            tok_b.kind    = pair_kind;
            tok_b.line    = tok_line_ff;
            tok_b.column  = tok_col_ff;
            tok_b.offset  = tok_off_ff;
            tok_b.length  = clst_pkg::LEN_W'(2);
         end

         cur_line_in = line_adv;
         cur_col_in  = col_adv;
         cur_off_in  = off_adv;
      end
   end

   // Pack the tokens of this beat, first in order, last flag on the final one
   logic a_valid;

   assign a_valid = do_flush && flush_has;

   always_comb begin
      push = '0;
      if (a_valid && b_valid) begin
         push.count       = 2'd2;
         push.first       = flush_tok;
         push.second      = tok_b;
         push.second.last = 1'b1;
      end else if (a_valid) begin
         push.count      = 2'd1;
         push.first      = flush_tok;
         push.first.last = 1'b1;
      end else if (b_valid) begin
         push.count      = 2'd1;
         push.first      = tok_b;
         push.first.last = 1'b1;
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= M_IDLE;
         pend_ff     <= '0;
         cur_line_ff <= clst_pkg::POS_W'(1);
         cur_col_ff  <= clst_pkg::POS_W'(1);
         cur_off_ff  <= '0;
         tok_line_ff <= clst_pkg::POS_W'(1);
         tok_col_ff  <= clst_pkg::POS_W'(1);
         tok_off_ff  <= '0;
         acc_ff      <= '0;
         ovf_ff      <= 1'b0;
         len_ff      <= '0;
         pfx_ff      <= '0;
      end else begin
         mode_ff     <= mode_in;
         pend_ff     <= pend_in;
         cur_line_ff <= cur_line_in;
         cur_col_ff  <= cur_col_in;
         cur_off_ff  <= cur_off_in;
         tok_line_ff <= tok_line_in;
         tok_col_ff  <= tok_col_in;
         tok_off_ff  <= tok_off_in;
         acc_ff      <= acc_in;
         ovf_ff      <= ovf_in;
         len_ff      <= len_in;
         pfx_ff      <= pfx_in;
      end
   end

endmodule

// ----- src/clst_rsp_queue.sv -----
// ----------------------------------------------------------------------------
// clst_rsp_queue: result token queue
// A small register queue that takes up to two tokens per cycle from the
// lexer and presents one token beat per cycle on the result channel while it is ready.
// ----------------------------------------------------------------------------
module clst_rsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  clst_pkg::push_type  push,
   input  logic                pop,
   output clst_pkg::token_type head,
   output logic                not_empty,
   output logic                room
);

   clst_pkg::token_type         entry_ff [clst_pkg::Q_DEPTH];
   logic [clst_pkg::Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [clst_pkg::Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [clst_pkg::Q_PTR_W-1:0] wr_next;
   logic [clst_pkg::Q_CNT_W-1:0] count_ff, count_in;

   // Pointer and fill bookkeeping
   assign wr_next   = wr_ptr_ff + clst_pkg::Q_PTR_W'(1);
   assign wr_ptr_in = wr_ptr_ff + clst_pkg::Q_PTR_W'(push.count);
   assign rd_ptr_in = pop ? rd_ptr_ff + clst_pkg::Q_PTR_W'(1) : rd_ptr_ff;
   assign count_in  = count_ff + clst_pkg::Q_CNT_W'(push.count) - clst_pkg::Q_CNT_W'(pop);

   // Room for two more tokens regardless of this cycle's pop
   assign room      = (count_ff <= clst_pkg::Q_CNT_W'(clst_pkg::Q_DEPTH - 2));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Token storage: first token at the write pointer, second just after it
   always_ff @(posedge clock) begin
      for (int e = 0; e < clst_pkg::Q_DEPTH; e++) begin
         if (push.count != 2'd0 && clst_pkg::Q_PTR_W'(e) == wr_ptr_ff) begin
            entry_ff[e] <= push.first;
         end else if (push.count == 2'd2 && clst_pkg::Q_PTR_W'(e) == wr_next) begin
            entry_ff[e] <= push.second;
         end
      end
   end

endmodule
